// File: rtl/sgi_pkg.sv
`default_nettype none
package sgi_pkg;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_CROSS = 2'd1,
        KIND_COLL  = 2'd2
    } hit_kind_t;

    // result of the parallel / collinear path, decided early in the pipe
    typedef struct packed {
        logic      par;
        hit_kind_t kind;
    } par_res_t;

    // sign and range flags that travel with the quotient
    typedef struct packed {
        logic negx;
        logic negy;
        logic ovf;
    } div_flags_t;

    // endpoint slots in the packed point word
    localparam int P1X = 0;
    localparam int P1Y = 1;
    localparam int P2X = 2;
    localparam int P2Y = 3;
    localparam int P3X = 4;
    localparam int P3Y = 5;
    localparam int P4X = 6;
    localparam int P4Y = 7;

endpackage
`default_nettype wire

// File: rtl/segment_intersection.sv
// Exact intersection of two 2-D segments with signed COORD_WIDTH-bit ends.
// One segment pair is accepted every cycle while in_ready is high, and one
// result word comes out per pair, in order. The stages run in this order:
// three front stages form differences, cross products and the collinear
// answer, three more build and normalize the exact crossing numerators, then
// a restoring divider yields one quotient bit per stage, and a final stage
// applies the signs, box tests and output register. Each stage holds its
// word when the next one is full, so a stalled output does not stop
// accepting pairs until the pipeline bubbles are used up.
`default_nettype none
module segment_intersection
    import sgi_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] a_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] a_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] a_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] a_end_y,
    input  wire logic signed [COORD_WIDTH-1:0] b_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] b_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] b_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] b_end_y,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               hit,
    output logic [1:0]                         hit_kind,
    output logic signed [COORD_WIDTH-1:0]      point_x,
    output logic signed [COORD_WIDTH-1:0]      point_y
);
    localparam int W      = COORD_WIDTH;
    localparam int DW     = 2 * W + 3;
    localparam int NW     = 3 * W + 5;
    localparam int NS     = W + 7;
    localparam int TAG_W  = 10 * W + $bits(par_res_t);
    localparam int DTAG_W = TAG_W + $bits(div_flags_t);

    // stage valid bits and per-stage load enables
    logic [NS-1:0] v_reg, v_next, en;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next = {v_reg[NS-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];

    logic [7:0][W-1:0] pts_in;

    assign pts_in[P1X] = a_start_x;
    assign pts_in[P1Y] = a_start_y;
    assign pts_in[P2X] = a_end_x;
    assign pts_in[P2Y] = a_end_y;
    assign pts_in[P3X] = b_start_x;
    assign pts_in[P3Y] = b_start_y;
    assign pts_in[P4X] = b_end_x;
    assign pts_in[P4Y] = b_end_y;

    logic signed [DW-1:0] f_d, f_c;
    logic signed [W-1:0]  f_x0, f_y0;
    logic signed [W:0]    f_ax, f_ay;
    logic [7:0][W-1:0]    f_pts;
    par_res_t             f_pres;
    logic [W-1:0]         f_ppx, f_ppy;

    sgi_front #(.W(W), .DW(DW)) u_front (
        .clk      (clk),
        .en       (en[2:0]),
        .pts_in   (pts_in),
        .d_out    (f_d),
        .c_out    (f_c),
        .x0_out   (f_x0),
        .y0_out   (f_y0),
        .ax_out   (f_ax),
        .ay_out   (f_ay),
        .pts_out  (f_pts),
        .pres_out (f_pres),
        .ppx_out  (f_ppx),
        .ppy_out  (f_ppy)
    );

    logic [NW-1:0]    n_magx, n_magy;
    logic [DW-1:0]    n_magd;
    div_flags_t       n_flags;
    logic [TAG_W-1:0] n_tag;

    sgi_num #(.W(W), .DW(DW), .NW(NW), .TAG_W(TAG_W)) u_num (
        .clk       (clk),
        .en        (en[5:3]),
        .d_in      (f_d),
        .c_in      (f_c),
        .x0_in     (f_x0),
        .y0_in     (f_y0),
        .ax_in     (f_ax),
        .ay_in     (f_ay),
        .tag_in    ({f_pts, f_pres, f_ppx, f_ppy}),
        .magx_out  (n_magx),
        .magy_out  (n_magy),
        .magd_out  (n_magd),
        .flags_out (n_flags),
        .tag_out   (n_tag)
    );

    logic [W-1:0]      q_magx, q_magy;
    logic [DTAG_W-1:0] q_tag;

    sgi_div #(.W(W), .DW(DW), .NW(NW), .TAG_W(DTAG_W)) u_div (
        .clk     (clk),
        .en      (en[W+5:6]),
        .nx_in   (n_magx),
        .ny_in   (n_magy),
        .d_in    (n_magd),
        .tag_in  ({n_flags, n_tag}),
        .qx_out  (q_magx),
        .qy_out  (q_magy),
        .tag_out (q_tag)
    );

    div_flags_t        o_flags;
    logic [7:0][W-1:0] o_pts;
    par_res_t          o_pres;
    logic [W-1:0]      o_ppx, o_ppy;

    assign {o_flags, o_pts, o_pres, o_ppx, o_ppy} = q_tag;

    function automatic logic signed [W:0] ext(input logic [W-1:0] v);
        return $signed({v[W-1], v});
    endfunction

    function automatic logic in_rng(input logic signed [W:0] s, input logic signed [W:0] m,
                                    input logic signed [W:0] e);
        return (s <= m && m <= e) || (e <= m && m <= s);
    endfunction

    logic signed [W:0] qx, qy;
    logic              cross_hit;
    logic              hit_next;
    hit_kind_t         kind_next;
    logic [W-1:0]      px_next, py_next;

    always_comb
    begin
        qx = o_flags.negx ? -$signed({1'b0, q_magx}) : $signed({1'b0, q_magx});
        qy = o_flags.negy ? -$signed({1'b0, q_magy}) : $signed({1'b0, q_magy});
        cross_hit = !o_flags.ovf &&
                    in_rng(ext(o_pts[P1X]), qx, ext(o_pts[P2X])) &&
                    in_rng(ext(o_pts[P1Y]), qy, ext(o_pts[P2Y])) &&
                    in_rng(ext(o_pts[P3X]), qx, ext(o_pts[P4X])) &&
                    in_rng(ext(o_pts[P3Y]), qy, ext(o_pts[P4Y]));
        if (o_pres.par)
        begin
            kind_next = o_pres.kind;
            px_next   = o_ppx;
            py_next   = o_ppy;
        end
        else if (cross_hit)
        begin
            kind_next = KIND_CROSS;
            px_next   = qx[W-1:0];
            py_next   = qy[W-1:0];
        end
        else
        begin
            kind_next = KIND_NONE;
            px_next   = '0;
            py_next   = '0;
        end
        hit_next = kind_next != KIND_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            hit      <= hit_next;
            hit_kind <= kind_next;
            point_x  <= px_next;
            point_y  <= py_next;
        end
    end

    a_hit_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit == (hit_kind != KIND_NONE)))
        else $error("hit flag disagrees with hit kind");

    a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (point_x == '0 && point_y == '0))
        else $error("point not cleared on miss");

    a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!(in_valid && in_ready) && !(out_valid && out_ready))
        |=> ($countones(v_reg) == $past($countones(v_reg))))
        else $error("word lost or created in pipeline");

endmodule
`default_nettype wire

// File: rtl/sgi_front.sv
`default_nettype none
module sgi_front
    import sgi_pkg::*;
#(
    parameter int W  = 16,
    parameter int DW = 2 * W + 3
)(
    input  wire logic                 clk,
    input  wire logic [2:0]           en,
    input  wire logic [7:0][W-1:0]    pts_in,
    output logic signed [DW-1:0]      d_out,
    output logic signed [DW-1:0]      c_out,
    output logic signed [W-1:0]       x0_out,
    output logic signed [W-1:0]       y0_out,
    output logic signed [W:0]         ax_out,
    output logic signed [W:0]         ay_out,
    output logic [7:0][W-1:0]         pts_out,
    output par_res_t                  pres_out,
    output logic [W-1:0]              ppx_out,
    output logic [W-1:0]              ppy_out
);
    localparam int PW = 2 * W + 2;

    function automatic logic signed [W:0] ext(input logic [W-1:0] v);
        return $signed({v[W-1], v});
    endfunction

    function automatic logic in_rng(input logic [W-1:0] s, input logic [W-1:0] m,
                                    input logic [W-1:0] e);
        logic signed [W-1:0] ss, mm, ee;
        ss = $signed(s);
        mm = $signed(m);
        ee = $signed(e);
        return (ss <= mm && mm <= ee) || (ee <= mm && mm <= ss);
    endfunction

    // stage 1: differences
    logic [7:0][W-1:0] pts1_reg;
    logic signed [W:0] dxa_reg, dya_reg, dxb_reg, dyb_reg, ex_reg, ey_reg;
    logic              va_reg, vb_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pts1_reg <= pts_in;
            dxa_reg  <= ext(pts_in[P2X]) - ext(pts_in[P1X]);
            dya_reg  <= ext(pts_in[P2Y]) - ext(pts_in[P1Y]);
            dxb_reg  <= ext(pts_in[P4X]) - ext(pts_in[P3X]);
            dyb_reg  <= ext(pts_in[P4Y]) - ext(pts_in[P3Y]);
            ex_reg   <= ext(pts_in[P3X]) - ext(pts_in[P1X]);
            ey_reg   <= ext(pts_in[P3Y]) - ext(pts_in[P1Y]);
            va_reg   <= pts_in[P2X] == pts_in[P1X];
            vb_reg   <= pts_in[P4X] == pts_in[P3X];
        end
    end

    // stage 2: cross products
    logic [7:0][W-1:0]  pts2_reg;
    logic signed [W:0]  dxa2_reg, dya2_reg, dxb2_reg, dyb2_reg, ex2_reg;
    logic               va2_reg, vb2_reg;
    logic signed [PW-1:0] m_ab_reg, m_ba_reg, m_c1_reg, m_c2_reg, m_l1_reg, m_l2_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            pts2_reg <= pts1_reg;
            dxa2_reg <= dxa_reg;
            dya2_reg <= dya_reg;
            dxb2_reg <= dxb_reg;
            dyb2_reg <= dyb_reg;
            ex2_reg  <= ex_reg;
            va2_reg  <= va_reg;
            vb2_reg  <= vb_reg;
            m_ab_reg <= dya_reg * dxb_reg;
            m_ba_reg <= dyb_reg * dxa_reg;
            m_c1_reg <= ex_reg * dyb_reg;
            m_c2_reg <= ey_reg * dxb_reg;
            m_l1_reg <= ex_reg * dya_reg;
            m_l2_reg <= ey_reg * dxa_reg;
        end
    end

    // stage 3: classify, pick divider operands, collinear endpoint
    logic signed [DW-1:0] d_next, c_next;
    logic signed [W-1:0]  x0_next, y0_next;
    logic signed [W:0]    ax_next, ay_next;
    par_res_t             pres_next;
    logic [W-1:0]         ppx_next, ppy_next;
    logic                 par, coll;

    always_comb
    begin
        par = 1'b0;
        coll = 1'b0;
        if (va2_reg && vb2_reg)
        begin
            par  = 1'b1;
            coll = pts2_reg[P1X] == pts2_reg[P3X];
        end
        else if (!va2_reg && !vb2_reg)
        begin
            par  = m_ab_reg == m_ba_reg;
            coll = m_l1_reg == m_l2_reg;
        end

        if (va2_reg)
        begin
            d_next  = DW'(dxb2_reg);
            x0_next = $signed(pts2_reg[P1X]);
            ax_next = '0;
            y0_next = $signed(pts2_reg[P3Y]);
            ay_next = dyb2_reg;
            c_next  = -(DW'(ex2_reg));
        end
        else if (vb2_reg)
        begin
            d_next  = DW'(dxa2_reg);
            x0_next = $signed(pts2_reg[P3X]);
            ax_next = '0;
            y0_next = $signed(pts2_reg[P1Y]);
            ay_next = dya2_reg;
            c_next  = DW'(ex2_reg);
        end
        else
        begin
            d_next  = DW'(m_ba_reg) - DW'(m_ab_reg);
            x0_next = $signed(pts2_reg[P1X]);
            ax_next = dxa2_reg;
            y0_next = $signed(pts2_reg[P1Y]);
            ay_next = dya2_reg;
            c_next  = DW'(m_c1_reg) - DW'(m_c2_reg);
        end

        pres_next.par  = par;
        pres_next.kind = KIND_NONE;
        ppx_next = '0;
        ppy_next = '0;
        if (par && coll)
        begin
            if (in_rng(pts2_reg[P1X], pts2_reg[P3X], pts2_reg[P2X]) &&
                in_rng(pts2_reg[P1Y], pts2_reg[P3Y], pts2_reg[P2Y]))
            begin
                pres_next.kind = KIND_COLL;
                ppx_next = pts2_reg[P3X];
                ppy_next = pts2_reg[P3Y];
            end
            else if (in_rng(pts2_reg[P1X], pts2_reg[P4X], pts2_reg[P2X]) &&
                     in_rng(pts2_reg[P1Y], pts2_reg[P4Y], pts2_reg[P2Y]))
            begin
                pres_next.kind = KIND_COLL;
                ppx_next = pts2_reg[P4X];
                ppy_next = pts2_reg[P4Y];
            end
            else if (in_rng(pts2_reg[P3X], pts2_reg[P1X], pts2_reg[P4X]) &&
                     in_rng(pts2_reg[P3Y], pts2_reg[P1Y], pts2_reg[P4Y]))
            begin
                pres_next.kind = KIND_COLL;
                ppx_next = pts2_reg[P1X];
                ppy_next = pts2_reg[P1Y];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            d_out    <= d_next;
            c_out    <= c_next;
            x0_out   <= x0_next;
            y0_out   <= y0_next;
            ax_out   <= ax_next;
            ay_out   <= ay_next;
            pts_out  <= pts2_reg;
            pres_out <= pres_next;
            ppx_out  <= ppx_next;
            ppy_out  <= ppy_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/sgi_num.sv
`default_nettype none
module sgi_num
    import sgi_pkg::*;
#(
    parameter int W     = 16,
    parameter int DW    = 2 * W + 3,
    parameter int NW    = 3 * W + 5,
    parameter int TAG_W = 1
)(
    input  wire logic                 clk,
    input  wire logic [2:0]           en,
    input  wire logic signed [DW-1:0] d_in,
    input  wire logic signed [DW-1:0] c_in,
    input  wire logic signed [W-1:0]  x0_in,
    input  wire logic signed [W-1:0]  y0_in,
    input  wire logic signed [W:0]    ax_in,
    input  wire logic signed [W:0]    ay_in,
    input  wire logic [TAG_W-1:0]     tag_in,
    output logic [NW-1:0]             magx_out,
    output logic [NW-1:0]             magy_out,
    output logic [DW-1:0]             magd_out,
    output div_flags_t                flags_out,
    output logic [TAG_W-1:0]          tag_out
);
    // low halves are taken unsigned, high halves signed
    localparam int L = W + 2;

    // stage 4: partial products
    logic signed [W+L:0]   xdl_reg, ydl_reg;
    logic signed [2*W:0]   xdh_reg, ydh_reg;
    logic signed [W+L+1:0] acl_reg, bcl_reg;
    logic signed [2*W+1:0] ach_reg, bch_reg;
    logic signed [DW-1:0]  d4_reg;
    logic [TAG_W-1:0]      tag4_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            xdl_reg  <= x0_in * $signed({1'b0, d_in[L-1:0]});
            ydl_reg  <= y0_in * $signed({1'b0, d_in[L-1:0]});
            xdh_reg  <= x0_in * $signed(d_in[DW-1:L]);
            ydh_reg  <= y0_in * $signed(d_in[DW-1:L]);
            acl_reg  <= ax_in * $signed({1'b0, c_in[L-1:0]});
            bcl_reg  <= ay_in * $signed({1'b0, c_in[L-1:0]});
            ach_reg  <= ax_in * $signed(c_in[DW-1:L]);
            bch_reg  <= ay_in * $signed(c_in[DW-1:L]);
            d4_reg   <= d_in;
            tag4_reg <= tag_in;
        end
    end

    // stage 5: numerators
    logic signed [NW-1:0] nx_reg, ny_reg;
    logic signed [DW-1:0] d5_reg;
    logic [TAG_W-1:0]     tag5_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            nx_reg   <= ((NW'(xdh_reg) + NW'(ach_reg)) <<< L) + NW'(xdl_reg) + NW'(acl_reg);
            ny_reg   <= ((NW'(ydh_reg) + NW'(bch_reg)) <<< L) + NW'(ydl_reg) + NW'(bcl_reg);
            d5_reg   <= d4_reg;
            tag5_reg <= tag4_reg;
        end
    end

    // stage 6: magnitudes, quotient signs, out-of-range check
    logic [NW-1:0] magx_next, magy_next, dsh;
    logic [DW-1:0] magd_next;
    div_flags_t    flags_next;

    always_comb
    begin
        magx_next = nx_reg[NW-1] ? (~nx_reg + 1'b1) : nx_reg;
        magy_next = ny_reg[NW-1] ? (~ny_reg + 1'b1) : ny_reg;
        magd_next = d5_reg[DW-1] ? (~d5_reg + 1'b1) : d5_reg;
        dsh = NW'({magd_next, {W{1'b0}}});
        // a quotient of 2**W or more lies outside every box
        flags_next.ovf  = (magx_next >= dsh) || (magy_next >= dsh);
        flags_next.negx = nx_reg[NW-1] ^ d5_reg[DW-1];
        flags_next.negy = ny_reg[NW-1] ^ d5_reg[DW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            magx_out  <= magx_next;
            magy_out  <= magy_next;
            magd_out  <= magd_next;
            flags_out <= flags_next;
            tag_out   <= tag5_reg;
        end
    end

endmodule
`default_nettype wire

// File: rtl/sgi_div.sv
`default_nettype none
module sgi_div #(
    parameter int W     = 16,
    parameter int DW    = 2 * W + 3,
    parameter int NW    = 3 * W + 5,
    parameter int TAG_W = 1
)(
    input  wire logic             clk,
    input  wire logic [W-1:0]     en,
    input  wire logic [NW-1:0]    nx_in,
    input  wire logic [NW-1:0]    ny_in,
    input  wire logic [DW-1:0]    d_in,
    input  wire logic [TAG_W-1:0] tag_in,
    output logic [W-1:0]          qx_out,
    output logic [W-1:0]          qy_out,
    output logic [TAG_W-1:0]      tag_out
);
    logic [NW-1:0]    rx_reg  [W];
    logic [NW-1:0]    ry_reg  [W];
    logic [DW-1:0]    d_reg   [W];
    logic [W-1:0]     qx_reg  [W];
    logic [W-1:0]     qy_reg  [W];
    logic [TAG_W-1:0] tag_reg [W];

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < W; k++)
    begin : g_stage
        localparam int I = W - 1 - k;
        logic [NW-1:0]    rx_in, ry_in, dsh, rx_next, ry_next;
        logic [DW-1:0]    dd_in;
        logic [W-1:0]     qx_in, qy_in, qx_next, qy_next;
        logic [TAG_W-1:0] t_in;

        if (k == 0)
        begin : g_first
            assign rx_in = nx_in;
            assign ry_in = ny_in;
            assign dd_in = d_in;
            assign qx_in = '0;
            assign qy_in = '0;
            assign t_in  = tag_in;
        end
        else
        begin : g_rest
            assign rx_in = rx_reg[k-1];
            assign ry_in = ry_reg[k-1];
            assign dd_in = d_reg[k-1];
            assign qx_in = qx_reg[k-1];
            assign qy_in = qy_reg[k-1];
            assign t_in  = tag_reg[k-1];
        end

        always_comb
        begin
            dsh = NW'(dd_in) << I;
            rx_next = rx_in;
            ry_next = ry_in;
            qx_next = qx_in;
            qy_next = qy_in;
            if (rx_in >= dsh)
            begin
                rx_next = rx_in - dsh;
                qx_next = qx_in | (W'(1) << I);
            end
            if (ry_in >= dsh)
            begin
                ry_next = ry_in - dsh;
                qy_next = qy_in | (W'(1) << I);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rx_reg[k]  <= rx_next;
                ry_reg[k]  <= ry_next;
                d_reg[k]   <= dd_in;
                qx_reg[k]  <= qx_next;
                qy_reg[k]  <= qy_next;
                tag_reg[k] <= t_in;
            end
        end
    end

    assign qx_out  = qx_reg[W-1];
    assign qy_out  = qy_reg[W-1];
    assign tag_out = tag_reg[W-1];

endmodule
`default_nettype wire

// File: test/tb.sv
`default_nettype none
module tb;
    import sgi_pkg::*;

    localparam int CW = 16;
    localparam int N_RANDOM = 1030;
    localparam int LATENCY = CW + 7;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    } seg_pair_t;

    typedef struct packed {
        logic      hit;
        hit_kind_t kind;
        coord_t    px;
        coord_t    py;
    } crossing_t;

    // directed row: pair, plus a typed-in answer where obvious
    typedef struct packed {
        seg_pair_t pair;
        logic      fixed;
        crossing_t want;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    seg_pair_t drv;
    logic out_valid;
    logic out_ready;
    logic hit;
    logic [1:0] hit_kind;
    coord_t point_x;
    coord_t point_y;

    crossing_t crossing_q[$];
    int mismatches;
    int results_seen;
    logic long_hold;

    segment_intersection #(.COORD_WIDTH(CW)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .a_start_x(drv.ax0),
        .a_start_y(drv.ay0),
        .a_end_x(drv.ax1),
        .a_end_y(drv.ay1),
        .b_start_x(drv.bx0),
        .b_start_y(drv.by0),
        .b_end_x(drv.bx1),
        .b_end_y(drv.by1),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .hit(hit),
        .hit_kind(hit_kind),
        .point_x(point_x),
        .point_y(point_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic between(wide_t s, wide_t m, wide_t e);
        wide_t t;
        if (s > e)
        begin
            t = s;
            s = e;
            e = t;
        end
        return s <= m && m <= e;
    endfunction

    function automatic logic within_box(wide_t sx, wide_t sy, wide_t mx, wide_t my,
                                        wide_t ex, wide_t ey);
        return between(sx, mx, ex) && between(sy, my, ey);
    endfunction

    // SV signed division truncates toward zero
    function automatic crossing_t predict_crossing(seg_pair_t p);
        wide_t x1, y1, x2, y2, x3, y3, x4, y4;
        wide_t dxa, dya, dxb, dyb, den, c, qx, qy;
        logic va, vb, par, coll;
        hit_kind_t kind;
        crossing_t r;
        x1 = p.ax0; y1 = p.ay0; x2 = p.ax1; y2 = p.ay1;
        x3 = p.bx0; y3 = p.by0; x4 = p.bx1; y4 = p.by1;
        dxa = x2 - x1; dya = y2 - y1;
        dxb = x4 - x3; dyb = y4 - y3;
        va = dxa == 0;
        vb = dxb == 0;
        par = 1'b0;
        coll = 1'b0;
        kind = KIND_NONE;
        qx = 0;
        qy = 0;
        if (va && vb)
        begin
            par = 1'b1;
            coll = x1 == x3;
        end
        else if (!va && !vb)
        begin
            par = dya * dxb == dyb * dxa;
            coll = par && ((x3 - x1) * dya == (y3 - y1) * dxa);
        end
        if (par)
        begin
            if (coll)
            begin
                if (within_box(x1, y1, x3, y3, x2, y2))
                begin
                    qx = x3; qy = y3; kind = KIND_COLL;
                end
                else if (within_box(x1, y1, x4, y4, x2, y2))
                begin
                    qx = x4; qy = y4; kind = KIND_COLL;
                end
                else if (within_box(x3, y3, x1, y1, x4, y4))
                begin
                    qx = x1; qy = y1; kind = KIND_COLL;
                end
            end
        end
        else
        begin
            if (va)
            begin
                qx = x1;
                qy = (y3 * dxb + dyb * (x1 - x3)) / dxb;
            end
            else if (vb)
            begin
                qx = x3;
                qy = (y1 * dxa + dya * (x3 - x1)) / dxa;
            end
            else
            begin
                den = dxa * dyb - dya * dxb;
                c = (x3 - x1) * dyb - (y3 - y1) * dxb;
                qx = (x1 * den + dxa * c) / den;
                qy = (y1 * den + dya * c) / den;
            end
            if (within_box(x1, y1, qx, qy, x2, y2) && within_box(x3, y3, qx, qy, x4, y4))
                kind = KIND_CROSS;
        end
        if (kind == KIND_NONE)
        begin
            qx = 0;
            qy = 0;
        end
        r.hit = kind != KIND_NONE;
        r.kind = kind;
        r.px = qx[CW-1:0];
        r.py = qy[CW-1:0];
        return r;
    endfunction

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 40) - 20);
            default: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    // half the pairs on a small grid so parallel, collinear and vertical cases come up often
    function automatic seg_pair_t random_pair();
        seg_pair_t p;
        int mode;
        int shape;
        mode = $urandom_range(0, 9);
        mode = mode < 4 ? 0 : (mode < 9 ? 1 : 2);
        p.ax0 = rand_coord(mode); p.ay0 = rand_coord(mode);
        p.ax1 = rand_coord(mode); p.ay1 = rand_coord(mode);
        p.bx0 = rand_coord(mode); p.by0 = rand_coord(mode);
        p.bx1 = rand_coord(mode); p.by1 = rand_coord(mode);
        shape = $urandom_range(0, 7);
        case (shape)
            0: p.ax1 = p.ax0;
            1: p.bx1 = p.bx0;
            2:
            begin
                // parallel to segment a, collinear when both scale factors match
                p.bx0 = p.ax0 + (p.ax1 - p.ax0) * coord_t'($urandom_range(0, 2));
                p.by0 = p.ay0 + (p.ay1 - p.ay0) * coord_t'($urandom_range(0, 2));
                p.bx1 = p.bx0 - (p.ax1 - p.ax0);
                p.by1 = p.by0 - (p.ay1 - p.ay0);
            end
            3:
            begin
                p.bx1 = p.bx0 + (p.ax1 - p.ax0);
                p.by1 = p.by0 + (p.ay1 - p.ay0);
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pair(seg_pair_t p);
        crossing_q.push_back(predict_crossing(p));
        drv <= p;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic idle_gap();
        int gap;
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // receiver: a stall pattern of its own plus one long hold
    initial
    begin
        int phase;
        out_ready = 1'b0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            phase = phase + 1;
            if (long_hold)
                out_ready <= 1'b0;
            else if (phase % 200 < 60)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 4) != 0);
        end
    end

    initial
    begin
        long_hold = 1'b0;
        wait (results_seen >= 300);
        @(posedge clk);
        long_hold = 1'b1;
        repeat (120) @(posedge clk);
        long_hold = 1'b0;
    end

    always @(posedge clk)
    begin
        crossing_t want;
        crossing_t got;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen = results_seen + 1;
            got.hit = hit;
            got.kind = hit_kind_t'(hit_kind);
            got.px = point_x;
            got.py = point_y;
            if (crossing_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected word: hit=%0b kind=%0d x=%0d y=%0d",
                             got.hit, got.kind, got.px, got.py);
                mismatches = mismatches + 1;
            end
            else
            begin
                want = crossing_q.pop_front();
                if (got !== want)
                begin
                    if (mismatches < 10)
                        $display("mismatch: exp %0b/%0d (%0d,%0d) got %0b/%0d (%0d,%0d)",
                                 want.hit, want.kind, want.px, want.py,
                                 got.hit, got.kind, got.px, got.py);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    initial
    begin
        #30000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        row_t rows[$];
        row_t r;
        int i;
        int waited;
        mismatches = 0;
        results_seen = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        drv = '0;

        // general crossing at the origin
        r.pair = {-16'sd10, -16'sd10, 16'sd10, 16'sd10, -16'sd10, 16'sd10, 16'sd10, -16'sd10};
        r.fixed = 1; r.want = {1'b1, KIND_CROSS, 16'sd0, 16'sd0}; rows.push_back(r);
        // parallel and distinct
        r.pair = {16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd0, 16'sd1, 16'sd10, 16'sd11};
        r.fixed = 1; r.want = {1'b0, KIND_NONE, 16'sd0, 16'sd0}; rows.push_back(r);
        // collinear overlap, b start inside a
        r.pair = {16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd5, 16'sd5, 16'sd20, 16'sd20};
        r.fixed = 1; r.want = {1'b1, KIND_COLL, 16'sd5, 16'sd5}; rows.push_back(r);
        // collinear, b end inside a
        r.pair = {16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd20, 16'sd20, 16'sd3, 16'sd3};
        r.fixed = 1; r.want = {1'b1, KIND_COLL, 16'sd3, 16'sd3}; rows.push_back(r);
        // collinear, a inside b
        r.pair = {16'sd2, 16'sd2, 16'sd4, 16'sd4, 16'sd0, 16'sd0, 16'sd9, 16'sd9};
        r.fixed = 1; r.want = {1'b1, KIND_COLL, 16'sd2, 16'sd2}; rows.push_back(r);
        // collinear, disjoint
        r.pair = {16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd5, 16'sd5, 16'sd9, 16'sd9};
        r.fixed = 1; r.want = {1'b0, KIND_NONE, 16'sd0, 16'sd0}; rows.push_back(r);
        // two verticals, same x
        r.pair = {16'sd3, 16'sd0, 16'sd3, 16'sd10, 16'sd3, 16'sd4, 16'sd3, 16'sd20};
        r.fixed = 1; r.want = {1'b1, KIND_COLL, 16'sd3, 16'sd4}; rows.push_back(r);
        // two verticals, different x
        r.pair = {16'sd3, 16'sd0, 16'sd3, 16'sd10, 16'sd4, 16'sd0, 16'sd4, 16'sd10};
        r.fixed = 1; r.want = {1'b0, KIND_NONE, 16'sd0, 16'sd0}; rows.push_back(r);
        // a vertical, b slanted
        r.pair = {16'sd1, -16'sd5, 16'sd1, 16'sd5, 16'sd0, 16'sd0, 16'sd3, 16'sd1};
        r.fixed = 0; r.want = '0; rows.push_back(r);
        // b vertical, a slanted, negative truncation
        r.pair = {16'sd0, 16'sd0, 16'sd3, -16'sd1, 16'sd1, -16'sd5, 16'sd1, 16'sd5};
        r.fixed = 0; r.want = '0; rows.push_back(r);
        // point segments
        r.pair = {16'sd2, 16'sd2, 16'sd2, 16'sd2, 16'sd2, 16'sd2, 16'sd2, 16'sd2};
        r.fixed = 1; r.want = {1'b1, KIND_COLL, 16'sd2, 16'sd2}; rows.push_back(r);
        r.pair = {16'sd2, 16'sd2, 16'sd2, 16'sd2, 16'sd0, 16'sd0, 16'sd4, 16'sd4};
        r.fixed = 0; r.want = '0; rows.push_back(r);
        // lines cross outside the boxes
        r.pair = {16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd10, 16'sd0, 16'sd9, 16'sd1};
        r.fixed = 1; r.want = {1'b0, KIND_NONE, 16'sd0, 16'sd0}; rows.push_back(r);
        // extremes of the coordinate range
        r.pair = {16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
                  16'sh7fff, 16'sh8000};
        r.fixed = 0; r.want = '0; rows.push_back(r);
        r.pair = {16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                  16'sh8000, 16'sh8000};
        r.fixed = 0; r.want = '0; rows.push_back(r);
        r.pair = {16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
                  16'sh8000, 16'sh7fff};
        r.fixed = 0; r.want = '0; rows.push_back(r);
        r.pair = {16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
                  16'sh8000, 16'sh8000};
        r.fixed = 1; r.want = {1'b0, KIND_NONE, 16'sd0, 16'sd0}; rows.push_back(r);
        r.pair = '1;
        r.fixed = 1; r.want = {1'b1, KIND_COLL, -16'sd1, -16'sd1}; rows.push_back(r);
        r.pair = '0;
        r.fixed = 1; r.want = {1'b1, KIND_COLL, 16'sd0, 16'sd0}; rows.push_back(r);
        // near-parallel crossing with a large quotient
        r.pair = {-16'sd30000, -16'sd1, 16'sd30000, 16'sd1, -16'sd30000, 16'sd0,
                  16'sd30000, 16'sd1};
        r.fixed = 0; r.want = '0; rows.push_back(r);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < rows.size(); i++)
        begin
            send_pair(rows[i].pair);
            // typed answers double-check the predictor itself
            if (rows[i].fixed && crossing_q[$] !== rows[i].want)
            begin
                mismatches = mismatches + 1;
                $display("row %0d: predictor disagrees with table", i);
            end
        end

        i = 0;
        while (i < N_RANDOM)
        begin
            int burst;
            burst = $urandom_range(1, 40);
            while (burst > 0 && i < N_RANDOM)
            begin
                send_pair(random_pair());
                burst--;
                i++;
            end
            idle_gap();
        end
        in_valid <= 1'b0;

        waited = 0;
        while (crossing_q.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 5) @(posedge clk);
        if (mismatches == 0 && crossing_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire
